// File: src/sliding_window_maximum_core_defines.svh
// Assertion macros shared by the checker of the sliding window maximum core.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef SLIDING_WINDOW_MAXIMUM_CORE_DEFINES_SVH
`define SLIDING_WINDOW_MAXIMUM_CORE_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define SWM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define SWM_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: src/swm_pkg.sv
// Shared constants and types of the sliding window maximum core.
// No dependencies; imported by the cell, the top level and the checker.
package swm_pkg;

    localparam int WINDOW_MAX_DEF   = 64;
    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int CFG_W            = 7;
    localparam logic [CFG_W-1:0] WINDOW_RESET = CFG_W'(1);

    // Per-transaction controls broadcast along the row of cells
    typedef struct packed {
        logic advance;   // a sample is accepted this cycle
        logic drop;      // the front candidate leaves the window
        logic flush;     // start of a new sequence: treat the queue as empty
        logic clear;     // window size written: empty the queue
    } t_swm_ctl;

    // Status one cell shows its neighbors
    typedef struct packed {
        logic valid;     // cell holds a candidate
        logic keep;      // candidate survives the incoming sample
    } t_swm_link;

endpackage

// File: src/swm_cell.sv
// One slot of the candidate queue: value, age and valid flag.
// Shifts toward the front on a drop, takes the new sample when it becomes the back.
// Depends on swm_pkg.
module swm_cell #(
    parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF,
    parameter int AGE_W        = 7
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_head,
    input  swm_pkg::t_swm_ctl              i_ctl,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    input  swm_pkg::t_swm_link             i_prev,
    input  swm_pkg::t_swm_link             i_up,
    input  logic signed [SAMPLE_WIDTH-1:0] i_up_value,
    input  logic        [AGE_W-1:0]        i_up_age,
    output swm_pkg::t_swm_link             o_link,
    output logic signed [SAMPLE_WIDTH-1:0] o_value,
    output logic        [AGE_W-1:0]        o_age,
    output logic signed [SAMPLE_WIDTH-1:0] o_next_value
);
    import swm_pkg::*;

    logic                           r_valid;
    logic                           n_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_value;
    logic signed [SAMPLE_WIDTH-1:0] n_value;
    logic        [AGE_W-1:0]        r_age;
    logic        [AGE_W-1:0]        n_age;

    logic                           kill;
    logic                           keep_raw;
    logic                           src_keep;
    logic signed [SAMPLE_WIDTH-1:0] src_value;
    logic        [AGE_W-1:0]        src_age;
    logic                           prev_ok;

    always_comb begin
        // candidates not above the new sample are popped from the back
        kill      = (r_value <= i_sample);
        keep_raw  = r_valid && !kill && !i_ctl.flush;
        src_keep  = i_ctl.drop ? i_up.keep  : keep_raw;
        src_value = i_ctl.drop ? i_up_value : r_value;
        src_age   = i_ctl.drop ? i_up_age   : r_age;
        // the new sample lands in the first slot past the surviving candidates
        prev_ok   = i_head || (i_ctl.drop ? keep_raw : i_prev.keep);

        n_valid = r_valid;
        n_value = r_value;
        n_age   = r_age;
        if (i_ctl.clear) begin
            n_valid = 1'b0;
        end else if (i_ctl.advance) begin
            n_valid = src_keep || prev_ok;
            if (src_keep) begin
                n_value = src_value;
                n_age   = (src_age == '1) ? src_age : src_age + 1'b1;
            end else begin
                n_value = i_sample;
                n_age   = AGE_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_age   <= n_age;
    end

    assign o_link.valid = r_valid;
    assign o_link.keep  = keep_raw;
    assign o_value      = r_value;
    assign o_age        = r_age;
    assign o_next_value = n_value;

endmodule

// File: src/sliding_window_maximum_core.sv
// Sliding window maximum over a stream of signed samples, built as a row of queue cells.
// The result shows on o_m_tvalid in the cycle after its sample is accepted.
// Throughput: one sample per cycle unless a stalled result holds the input; every cell
// updates in a single step per transaction. Results appear from the window_size-th sample
// of a sequence on, one per sample. Reset (synchronous, i_rst_n low) empties the queue,
// clears the fill count and sets window_size to 1. Depends on swm_pkg and swm_cell.
module sliding_window_maximum_core #(
    parameter int WINDOW_MAX   = swm_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF,
    parameter int TDATA_W      = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_tvalid,
    output logic                      o_s_tready,
    input  logic [TDATA_W-1:0]        i_s_tdata,   // [SAMPLE_WIDTH-1:0] sample, rest zero
    input  logic                      i_s_tuser,   // [0] start_req
    output logic                      o_m_tvalid,
    input  logic                      i_m_tready,
    output logic [TDATA_W-1:0]        o_m_tdata,   // [SAMPLE_WIDTH-1:0] window_max, rest zero
    input  logic                      i_cfg_we,
    input  logic [swm_pkg::CFG_W-1:0] i_cfg_wdata
);
    import swm_pkg::*;

    localparam int AGE_W = $clog2(WINDOW_MAX + 1);

    logic [CFG_W-1:0]               r_window;
    logic [AGE_W-1:0]               r_fill;
    logic [AGE_W-1:0]               n_fill;
    logic                           r_out_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_out;

    logic                           accept;
    logic [AGE_W-1:0]               win_k;
    logic [AGE_W-1:0]               fill_base;
    logic                           emit;
    logic signed [SAMPLE_WIDTH-1:0] sample;
    t_swm_ctl                       ctl;

    t_swm_link                      link  [WINDOW_MAX];
    logic signed [SAMPLE_WIDTH-1:0] value [WINDOW_MAX];
    logic        [AGE_W-1:0]        age   [WINDOW_MAX];
    logic signed [SAMPLE_WIDTH-1:0] next_value [WINDOW_MAX];

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign accept     = i_s_tvalid && o_s_tready;
    assign sample     = signed'(i_s_tdata[SAMPLE_WIDTH-1:0]);

    // effective window: zero acts as one, oversize acts as WINDOW_MAX
    always_comb begin
        if (r_window == '0) begin
            win_k = AGE_W'(1);
        end else if (32'(r_window) > 32'(WINDOW_MAX)) begin
            win_k = AGE_W'(WINDOW_MAX);
        end else begin
            win_k = AGE_W'(r_window);
        end
    end

    always_comb begin
        ctl.clear   = i_cfg_we;
        ctl.advance = accept && !i_cfg_we;
        ctl.flush   = i_s_tuser;
        ctl.drop    = accept && !i_cfg_we && !i_s_tuser && link[0].valid && (age[0] >= win_k);

        fill_base = i_s_tuser ? '0 : r_fill;
        n_fill    = (32'(fill_base) < 32'(WINDOW_MAX)) ? fill_base + 1'b1 : fill_base;
        emit      = (n_fill >= win_k);
    end

    genvar gi;
    generate
        for (gi = 0; gi < WINDOW_MAX; gi++) begin : g_cell
            t_swm_link                      prev_link;
            t_swm_link                      up_link;
            logic signed [SAMPLE_WIDTH-1:0] up_value;
            logic        [AGE_W-1:0]        up_age;

            if (gi == 0) begin : g_head
                assign prev_link = '0;
            end else begin : g_body
                assign prev_link = link[gi-1];
            end

            if (gi == WINDOW_MAX - 1) begin : g_tail
                assign up_link  = '0;
                assign up_value = '0;
                assign up_age   = '0;
            end else begin : g_inner
                assign up_link  = link[gi+1];
                assign up_value = value[gi+1];
                assign up_age   = age[gi+1];
            end

            swm_cell #(
                .SAMPLE_WIDTH (SAMPLE_WIDTH),
                .AGE_W        (AGE_W)
            ) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_head       (gi == 0),
                .i_ctl        (ctl),
                .i_sample     (sample),
                .i_prev       (prev_link),
                .i_up         (up_link),
                .i_up_value   (up_value),
                .i_up_age     (up_age),
                .o_link       (link[gi]),
                .o_value      (value[gi]),
                .o_age        (age[gi]),
                .o_next_value (next_value[gi])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window    <= WINDOW_RESET;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_window <= i_cfg_wdata;
                r_fill   <= '0;
            end else if (accept) begin
                r_fill <= n_fill;
            end
            if (ctl.advance && emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // front of the queue after the update is the window maximum
    always_ff @(posedge i_clk) begin
        if (ctl.advance && emit) begin
            r_out <= next_value[0];
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = TDATA_W'($unsigned(r_out));

endmodule

// File: src/swm_checker.sv
// Port-level checker for the sliding window maximum core, bound to the top level.
// Depends on sliding_window_maximum_core_defines.svh and swm_pkg.
`include "sliding_window_maximum_core_defines.svh"

module swm_checker #(
    parameter int TDATA_W = 16
) (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_s_tvalid,
    input logic                      o_s_tready,
    input logic [TDATA_W-1:0]        i_s_tdata,
    input logic                      i_s_tuser,
    input logic                      o_m_tvalid,
    input logic                      i_m_tready,
    input logic [TDATA_W-1:0]        o_m_tdata,
    input logic                      i_cfg_we,
    input logic [swm_pkg::CFG_W-1:0] i_cfg_wdata
);
    import swm_pkg::*;

    // a fresh result must come from a transaction on the input side
    `SWM_ASSERT(a_result_needs_input, $rose(o_m_tvalid) |-> $past(i_s_tvalid && o_s_tready), "result without accepted sample")

    // input stalls while a result waits
    `SWM_ASSERT(a_stall_blocks_input, (o_m_tvalid && !i_m_tready) |-> !o_s_tready, "input taken while output stalled")

    // reset drops any pending result
    `SWM_ASSERT_ALWAYS(a_reset_empties, !i_rst_n |=> !o_m_tvalid, "result valid after reset")

    // a waiting result holds its data
    `SWM_ASSERT(a_stall_holds_data, (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)), "stalled result changed")

endmodule

bind sliding_window_maximum_core swm_checker #(.TDATA_W(TDATA_W)) u_swm_checker (.*);

// File: test/tb_sliding_window_maximum_core.sv
// Self-checking testbench for sliding_window_maximum_core: streams signed samples
// through the block and checks each window maximum against an in-bench deque model.
// Depends on swm_pkg and the core RTL only.
module tb_sliding_window_maximum_core;
    timeunit 1ns;
    timeprecision 1ps;

    import swm_pkg::*;

    localparam int SW          = SAMPLE_WIDTH_DEF;
    localparam int WMAX        = WINDOW_MAX_DEF;
    localparam int HOLD_CYCLES = 200;
    localparam int STUCK_LIMIT = 2000;
    localparam int PHASE_ITEMS = 140;
    localparam int PRINT_CAP   = 20;

    typedef enum int {
        GEN_UNIFORM,
        GEN_FALLING,
        GEN_RISING,
        GEN_TIES,
        GEN_EXTREMES
    } t_gen_mode;

    typedef struct {
        logic signed [SW-1:0] sample;
        logic                 start;
    } t_sample_item;

    typedef struct {
        logic signed [SW-1:0] value;
        logic [6:0]           pos;
    } t_candidate;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_s_tvalid  = 1'b0;
    logic             o_s_tready;
    logic [SW-1:0]    i_s_tdata   = '0;   // [15:0] sample
    logic             i_s_tuser   = 1'b0; // [0] start_req
    logic             o_m_tvalid;
    logic             i_m_tready  = 1'b0;
    logic [SW-1:0]    o_m_tdata;          // [15:0] window_max
    logic             i_cfg_we    = 1'b0;
    logic [CFG_W-1:0] i_cfg_wdata = '0;

    sliding_window_maximum_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Stimulus and expected results
    t_sample_item  pending_samples[$];
    logic [SW-1:0] expected_max_q[$];
    t_sample_item  driven_item;

    // Deque model state
    t_candidate    candidates[$];
    logic [CFG_W-1:0] window_reg = WINDOW_RESET;
    logic [6:0]    position_ctr = '0;
    int            samples_filled = 0;

    // Run control
    int  mismatches     = 0;
    int  samples_queued = 0;
    int  samples_sent   = 0;
    int  results_seen   = 0;
    int  window_writes  = 0;
    int  idle_pct       = 0;
    bit  quiet          = 1'b0;
    bit  hold_armed     = 1'b0;
    int  src_gap        = 0;
    int  sink_gap       = 0;
    int  hold_left      = 0;
    int  stuck_cycles   = 0;
    logic [SW-1:0] want;

    task automatic flag_mismatch(input string what);
        if (mismatches < PRINT_CAP)
            $display("MISMATCH @%0t: %s", $realtime, what);
        mismatches++;
    endtask

    task automatic clear_window_state();
        candidates.delete();
        position_ctr   = '0;
        samples_filled = 0;
    endtask

    // Advance the deque model by one sample; queue the window maximum if one is due.
    task automatic track_window_max(input t_sample_item it);
        int         span;
        logic [6:0] pos;
        logic [6:0] age;
        t_candidate fresh;
        span = (window_reg == 0) ? 1 : (window_reg > WMAX) ? WMAX : int'(window_reg);
        if (it.start)
            clear_window_state();
        pos = position_ctr;
        while (candidates.size() > 0) begin
            age = pos - candidates[0].pos;
            if (int'(age) >= span)
                candidates.delete(0);
            else
                break;
        end
        // Drop back entries not above the new sample; the newest of equals stays
        while (candidates.size() > 0 && candidates[$].value <= it.sample)
            candidates.delete(candidates.size() - 1);
        if (candidates.size() >= WMAX)
            candidates.delete(0);
        fresh.value = it.sample;
        fresh.pos   = pos;
        candidates.insert(candidates.size(), fresh);
        position_ctr = pos + 7'd1;
        if (samples_filled < WMAX)
            samples_filled++;
        if (samples_filled >= span)
            expected_max_q.insert(expected_max_q.size(), candidates[0].value);
    endtask

    // Source side
    always @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            track_window_max(driven_item);
            samples_sent++;
        end
        if (!i_s_tvalid || o_s_tready) begin
            if (src_gap > 0) begin
                src_gap--;
                i_s_tvalid <= 1'b0;
            end else if (pending_samples.size() > 0) begin
                if (!quiet && idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
                    src_gap = $urandom_range(1, 19) - 1;
                    i_s_tvalid <= 1'b0;
                end else begin
                    driven_item = pending_samples[0];
                    pending_samples.delete(0);
                    i_s_tdata  <= driven_item.sample;
                    i_s_tuser  <= driven_item.start;
                    i_s_tvalid <= 1'b1;
                end
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // Sink side: check each result, then choose the next ready value
    always @(posedge i_clk) begin
        if (o_m_tvalid && i_m_tready) begin
            results_seen++;
            if (expected_max_q.size() == 0) begin
                flag_mismatch($sformatf("window_max %0d with nothing expected",
                                        $signed(o_m_tdata)));
            end else begin
                want = expected_max_q[0];
                expected_max_q.delete(0);
                if (o_m_tdata !== want)
                    flag_mismatch($sformatf("window_max got %0d expected %0d",
                                            $signed(o_m_tdata), $signed(want)));
            end
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else if (hold_armed && o_m_tvalid) begin
            hold_armed = 1'b0;
            hold_left  = HOLD_CYCLES - 1;
            i_m_tready <= 1'b0;
        end else if (quiet || idle_pct == 0) begin
            i_m_tready <= 1'b1;
        end else if (sink_gap > 0) begin
            sink_gap--;
            i_m_tready <= 1'b0;
        end else if ($urandom_range(0, 99) < idle_pct) begin
            sink_gap = $urandom_range(1, 19) - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // Watchdog: end the run if nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", STUCK_LIMIT);
            $display("** sliding_window_maximum_core: FAILED **");
            $finish;
        end
    end

    task automatic queue_sample(input logic signed [SW-1:0] s, input logic st);
        t_sample_item item;
        item.sample = s;
        item.start  = st;
        pending_samples.insert(pending_samples.size(), item);
        samples_queued++;
    endtask

    // Hold until every queued sample is taken and every result is back, then settle.
    task automatic wait_drained();
        while (samples_sent < samples_queued || expected_max_q.size() > 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_window(input logic [CFG_W-1:0] w);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= w;
        window_reg   = w;
        clear_window_state();
        window_writes++;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin : stimulus
        logic [CFG_W-1:0]     phase_window[9];
        t_gen_mode            phase_mode[9];
        logic signed [SW-1:0] s;
        logic                 st;

        phase_window = '{7'd64, 7'd127, 7'd65, 7'd1, 7'd2, 7'd0, 7'd0, 7'd64, 7'd0};
        phase_mode   = '{GEN_FALLING, GEN_UNIFORM, GEN_TIES, GEN_EXTREMES, GEN_RISING,
                         GEN_UNIFORM, GEN_FALLING, GEN_TIES, GEN_UNIFORM};
        phase_window[5] = CFG_W'($urandom_range(3, 63));
        phase_window[6] = CFG_W'($urandom_range(3, 63));
        phase_window[8] = CFG_W'($urandom_range(1, 64));

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset window of one: every sample is its own maximum
        queue_sample(-16'sd32768, 1'b0);
        queue_sample(16'sd32767, 1'b0);
        queue_sample(16'sd0, 1'b1);
        wait_drained();

        // Window of three: ties, both extremes, eviction of the front, restart mid-run
        write_window(7'd3);
        queue_sample(16'sd100, 1'b1);
        queue_sample(16'sd100, 1'b0);
        queue_sample(16'sd100, 1'b0);
        queue_sample(-16'sd32768, 1'b0);
        queue_sample(-16'sd32768, 1'b0);
        queue_sample(-16'sd32768, 1'b0);
        queue_sample(16'sd32767, 1'b0);
        queue_sample(-16'sd1, 1'b0);
        queue_sample(-16'sd2, 1'b0);
        queue_sample(-16'sd3, 1'b0);
        queue_sample(-16'sd4, 1'b0);
        queue_sample(16'sd0, 1'b1);
        queue_sample(16'sd5, 1'b0);
        queue_sample(16'sd5, 1'b0);
        queue_sample(-16'sd21846, 1'b0);
        queue_sample(16'sd21845, 1'b0);
        wait_drained();

        // Window size zero behaves as one
        write_window(7'd0);
        queue_sample(16'sd7, 1'b0);
        queue_sample(-16'sd7, 1'b0);
        wait_drained();

        for (int ph = 0; ph < 9; ph++) begin
            write_window(phase_window[ph]);
            idle_pct   = (ph % 3 == 2) ? 0 : 15;
            quiet      = (ph == 8);
            hold_armed = (ph == 0 || ph == 1);
            s = (phase_mode[ph] == GEN_RISING) ? -16'sd32768 : 16'sd32767;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                case (phase_mode[ph])
                    GEN_FALLING:  s = (s < -16'sd30000) ? 16'sd32767
                                                         : s - SW'($urandom_range(0, 40));
                    GEN_RISING:   s = (s > 16'sd30000) ? -16'sd32768
                                                        : s + SW'($urandom_range(0, 40));
                    GEN_TIES:     s = SW'($urandom_range(0, 3)) - 16'sd2;
                    GEN_EXTREMES: begin
                        case ($urandom_range(0, 3))
                            0:       s = -16'sd32768;
                            1:       s = 16'sd32767;
                            2:       s = 16'sd0;
                            default: s = -16'sd1;
                        endcase
                    end
                    default:      s = SW'($urandom);
                endcase
                // Mostly long sequences; now and then restart one early
                st = (n == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 59) == 0);
                queue_sample(s, st);
            end
            wait_drained();
        end

        repeat (8) @(posedge i_clk);
        if (expected_max_q.size() > 0)
            flag_mismatch($sformatf("%0d window maxima never arrived", expected_max_q.size()));
        $display("covered %0d samples, %0d window maxima, %0d window-size writes",
                 samples_sent, results_seen, window_writes);
        $display("window sizes included 0, 1, 64, 65 and 127; mismatches: %0d", mismatches);
        if (mismatches == 0)
            $display("** sliding_window_maximum_core: PASSED **");
        else
            $display("** sliding_window_maximum_core: FAILED **");
        $finish;
    end

endmodule
